### hdl/logfmt_line_tokenizer_top_assert.svh
// Assertion macros shared by the logfmt tokenizer RTL.
`ifndef LOGFMT_LINE_TOKENIZER_TOP_ASSERT_SVH
`define LOGFMT_LINE_TOKENIZER_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define LFT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("logfmt tokenizer check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define LFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("logfmt tokenizer check failed");

`endif

### hdl/lft_pkg.sv
// Shared types and constants of the logfmt line tokenizer.
package lft_pkg;

    // Scanner state codes.
    localparam logic [2:0] ST_SKIP   = 3'd0;
    localparam logic [2:0] ST_KEY    = 3'd1;
    localparam logic [2:0] ST_VSTART = 3'd2;
    localparam logic [2:0] ST_VUNQ   = 3'd3;
    localparam logic [2:0] ST_VQ     = 3'd4;
    localparam logic [2:0] ST_VESC   = 3'd5;

    // Byte roles.
    localparam logic [1:0] ROLE_NONE  = 2'd0;
    localparam logic [1:0] ROLE_KEY   = 2'd1;
    localparam logic [1:0] ROLE_VALUE = 2'd2;

    // Characters of interest.
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [7:0] PAIRS_MAX = 8'hFF;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_in;
    } item_t;

    typedef struct packed {
        logic [7:0] byte_out;
        logic [1:0] role;
        logic       key_commit;
        logic       key_discard;
        logic       pair_end;
        logic [7:0] line_pairs;
        logic       line_end;
    } result_t;

    typedef struct packed {
        logic [2:0] state;
        logic [7:0] count;
    } scan_status_t;

endpackage

### hdl/lft_if.sv
// Channel interfaces for the byte input and the tagged-byte output.
interface lft_in_if;
    import lft_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       last_in;

    modport source (output valid, output byte_in, output last_in, input ready);
    modport sink (input valid, input byte_in, input last_in, output ready);
endinterface

interface lft_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic [1:0] role;
    logic       key_commit;
    logic       key_discard;
    logic       pair_end;
    logic [7:0] line_pairs;
    logic       line_end;

    modport source (output valid, output byte_out, output role, output key_commit,
                    output key_discard, output pair_end, output line_pairs,
                    output line_end, input ready);
    modport sink (input valid, input byte_out, input role, input key_commit,
                  input key_discard, input pair_end, input line_pairs,
                  input line_end, output ready);
endinterface

### hdl/lft_in_stage.sv
// Input register: captures one byte transaction and holds it until the scanner takes it.
module lft_in_stage
    import lft_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    lft_in_if.sink     bytes,
    input  logic       take,
    output logic       valid,
    output item_t      item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    assign bytes.ready = !valid_reg || take;
    assign load        = bytes.valid && bytes.ready;
    assign valid_next  = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= '{byte_in: bytes.byte_in, last_in: bytes.last_in};
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

### hdl/lft_scan.sv
// Scanner: per-byte classification, the tokenizer state and the per-line pair count.
module lft_scan
    import lft_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         fire,
    input  item_t        item,
    output result_t      res,
    output scan_status_t status
);

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [7:0] count_reg;
    logic [7:0] count_next;

    logic [2:0] st_cur;
    logic [2:0] st_new;
    logic [1:0] role;
    logic       commit;
    logic       discard;
    logic       pend;
    logic       ws;
    logic [7:0] count_new;

    assign ws = (item.byte_in == CH_SPACE) || (item.byte_in == CH_TAB);

    always_comb
    begin
        // Unused codes fall back to whitespace skipping.
        st_cur  = (state_reg > ST_VESC) ? ST_SKIP : state_reg;
        st_new  = st_cur;
        role    = ROLE_NONE;
        commit  = 1'b0;
        discard = 1'b0;
        pend    = 1'b0;

        case (st_cur)
            ST_SKIP, ST_KEY:
            begin
                if (ws)
                begin
                    discard = (st_cur == ST_KEY);
                    st_new  = ST_SKIP;
                end
                else if (item.byte_in == CH_EQ)
                begin
                    commit = 1'b1;
                    st_new = ST_VSTART;
                end
                else
                begin
                    role   = ROLE_KEY;
                    st_new = ST_KEY;
                end
            end
            ST_VSTART:
            begin
                if (item.byte_in == CH_QUOTE)
                begin
                    st_new = ST_VQ;
                end
                else if (ws)
                begin
                    pend   = 1'b1;
                    st_new = ST_SKIP;
                end
                else
                begin
                    role   = ROLE_VALUE;
                    st_new = ST_VUNQ;
                end
            end
            ST_VUNQ:
            begin
                if (ws)
                begin
                    pend   = 1'b1;
                    st_new = ST_SKIP;
                end
                else
                begin
                    role = ROLE_VALUE;
                end
            end
            ST_VQ:
            begin
                if (item.byte_in == CH_QUOTE)
                begin
                    pend   = 1'b1;
                    st_new = ST_SKIP;
                end
                else if (item.byte_in == CH_BSL)
                begin
                    role   = ROLE_VALUE;
                    st_new = ST_VESC;
                end
                else
                begin
                    role = ROLE_VALUE;
                end
            end
            default:
            begin
                // Escaped byte inside quotes.
                role   = ROLE_VALUE;
                st_new = ST_VQ;
            end
        endcase

        // The end of the line closes whatever token is still open.
        if (item.last_in)
        begin
            if (st_new == ST_KEY)
            begin
                discard = 1'b1;
            end
            else if (st_new != ST_SKIP)
            begin
                pend = 1'b1;
            end
        end
    end

    assign count_new = (pend && (count_reg != PAIRS_MAX)) ? (count_reg + 8'd1) : count_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        if (fire)
        begin
            state_next = item.last_in ? ST_SKIP : st_new;
            count_next = item.last_in ? 8'd0 : count_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SKIP;
            count_reg <= 8'd0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    assign res = '{byte_out: item.byte_in, role: role, key_commit: commit,
                   key_discard: discard, pair_end: pend, line_pairs: count_new,
                   line_end: item.last_in};
    assign status = '{state: state_reg, count: count_reg};

endmodule

### hdl/lft_out_stage.sv
// Result register: holds one tagged byte until the output transaction completes.
module lft_out_stage
    import lft_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res,
    output logic    can_load,
    lft_out_if.source tags
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign can_load   = !valid_reg || tags.ready;
    assign valid_next = load ? 1'b1 : (tags.ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign tags.valid       = valid_reg;
    assign tags.byte_out    = res_reg.byte_out;
    assign tags.role        = res_reg.role;
    assign tags.key_commit  = res_reg.key_commit;
    assign tags.key_discard = res_reg.key_discard;
    assign tags.pair_end    = res_reg.pair_end;
    assign tags.line_pairs  = res_reg.line_pairs;
    assign tags.line_end    = res_reg.line_end;

endmodule

### hdl/logfmt_line_tokenizer_top.sv
// A byte accepted into the input register moves through the scanner into the result register.
// Throughput: one byte per cycle when not stalled; the scanner state updates as a byte moves
// from the input register into the result register, so bytes follow back to back.
// The input is ready whenever the input register is empty or moves on that cycle.
// Reset (rst_n low, asynchronous) empties both registers, sets the scanner to
// whitespace skipping and clears the pair count.
`include "logfmt_line_tokenizer_top_assert.svh"

module logfmt_line_tokenizer_top
    import lft_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    lft_in_if.sink    bytes,
    lft_out_if.source tags
);

    logic         in_valid;
    item_t        in_item;
    logic         can_load;
    logic         fire;
    result_t      res;
    scan_status_t status;

    assign fire = in_valid && can_load;

    lft_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .bytes (bytes),
        .take  (can_load),
        .valid (in_valid),
        .item  (in_item)
    );

    lft_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_item),
        .res    (res),
        .status (status)
    );

    lft_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire),
        .res      (res),
        .can_load (can_load),
        .tags     (tags)
    );

    // The last byte of a line leaves the scanner at its starting point.
    `LFT_ASSERT_NEXT(a_line_restart, clk, rst_n, fire && in_item.last_in,
        (status.state == ST_SKIP) && (status.count == 8'd0))

    // A stalled result must not let a buffered input byte slip away.
    `LFT_ASSERT_NEXT(a_no_drop, clk, rst_n, in_valid && tags.valid && !tags.ready,
        in_valid && $stable(in_item))

    // A completed pair is always counted in the line total.
    `LFT_ASSERT_NOW(a_pair_counted, clk, rst_n, tags.valid && tags.pair_end,
        tags.line_pairs != 8'd0)

    // Only an equals sign outside a value commits a key, and it carries no role.
    // It ends a pair only when it is the last byte of the line.
    `LFT_ASSERT_NOW(a_commit_eq, clk, rst_n, tags.valid && tags.key_commit,
        (tags.byte_out == CH_EQ) && (tags.role == ROLE_NONE) && (tags.line_end || !tags.pair_end))

endmodule

### sim/logfmt_line_tokenizer_top_tb.sv
// Self-checking testbench for the logfmt line tokenizer: directed and random lines.
module logfmt_line_tokenizer_top_tb;
    import lft_pkg::*;

    localparam int RANDOM_BYTES   = 980;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 8;

    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         hold;
    } feed_t;

    logic clk;
    logic rst_n;

    lft_in_if  bytes_if ();
    lft_out_if tags_if ();

    logfmt_line_tokenizer_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .bytes (bytes_if),
        .tags  (tags_if)
    );

    feed_t      byte_feed[$];
    logic [7:0] line_buf[$];
    result_t    tag_expect[$];
    result_t    seen_tag;

    // Shadow copy of the scanner state and the per-line pair count.
    logic [2:0] scan_st;
    logic [7:0] pair_cnt;

    int total_bytes;
    int bytes_taken;
    int tags_seen;
    int error_count;
    int quiet_cycles;
    bit in_fired;

    always #1 clk = ~clk;

    function automatic int send_idle_pct();
        if (bytes_taken < total_bytes / 3)
            return 35;
        else if (bytes_taken < (2 * total_bytes) / 3)
            return 84;
        return 0;
    endfunction

    function automatic int recv_idle_pct();
        if (bytes_taken < total_bytes / 3)
            return 84;
        else if (bytes_taken < (2 * total_bytes) / 3)
            return 35;
        return 0;
    endfunction

    // Tags one byte and advances the shadow scanner.
    function automatic result_t tag_byte(input logic [7:0] c, input logic last);
        result_t    r;
        logic [2:0] st;
        logic       ws;
        st = (scan_st > ST_VESC) ? ST_SKIP : scan_st;
        ws = (c == CH_SPACE) || (c == CH_TAB);
        r = '0;
        r.byte_out = c;
        r.line_end = last;
        r.role = ROLE_NONE;
        case (st)
            ST_SKIP, ST_KEY:
            begin
                if (ws)
                begin
                    r.key_discard = (st == ST_KEY);
                    st = ST_SKIP;
                end
                else if (c == CH_EQ)
                begin
                    r.key_commit = 1'b1;
                    st = ST_VSTART;
                end
                else
                begin
                    r.role = ROLE_KEY;
                    st = ST_KEY;
                end
            end
            ST_VSTART:
            begin
                if (c == CH_QUOTE)
                    st = ST_VQ;
                else if (ws)
                begin
                    r.pair_end = 1'b1;
                    st = ST_SKIP;
                end
                else
                begin
                    r.role = ROLE_VALUE;
                    st = ST_VUNQ;
                end
            end
            ST_VUNQ:
            begin
                if (ws)
                begin
                    r.pair_end = 1'b1;
                    st = ST_SKIP;
                end
                else
                    r.role = ROLE_VALUE;
            end
            ST_VQ:
            begin
                if (c == CH_QUOTE)
                begin
                    r.pair_end = 1'b1;
                    st = ST_SKIP;
                end
                else if (c == CH_BSL)
                begin
                    r.role = ROLE_VALUE;
                    st = ST_VESC;
                end
                else
                    r.role = ROLE_VALUE;
            end
            default:
            begin
                r.role = ROLE_VALUE;
                st = ST_VQ;
            end
        endcase
        // The last byte closes whatever is still open.
        if (last)
        begin
            if (st == ST_KEY)
                r.key_discard = 1'b1;
            else if (st != ST_SKIP)
                r.pair_end = 1'b1;
        end
        if (r.pair_end && pair_cnt != PAIRS_MAX)
            pair_cnt = pair_cnt + 8'd1;
        r.line_pairs = pair_cnt;
        if (last)
        begin
            scan_st = ST_SKIP;
            pair_cnt = '0;
        end
        else
            scan_st = st;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH result %0d: %s is %0h, expected %0h", tags_seen, what, got, want);
        error_count = error_count + 1;
    endtask

    task automatic check_tag(input result_t got);
        result_t want;
        if (tag_expect.size() == 0)
        begin
            report_mismatch("result with nothing pending, byte_out", got.byte_out, 0);
            return;
        end
        want = tag_expect.pop_front();
        if (got.byte_out !== want.byte_out)
            report_mismatch("byte_out", got.byte_out, want.byte_out);
        if (got.role !== want.role)
            report_mismatch("role", got.role, want.role);
        if (got.key_commit !== want.key_commit)
            report_mismatch("key_commit", got.key_commit, want.key_commit);
        if (got.key_discard !== want.key_discard)
            report_mismatch("key_discard", got.key_discard, want.key_discard);
        if (got.pair_end !== want.pair_end)
            report_mismatch("pair_end", got.pair_end, want.pair_end);
        if (got.line_pairs !== want.line_pairs)
            report_mismatch("line_pairs", got.line_pairs, want.line_pairs);
        if (got.line_end !== want.line_end)
            report_mismatch("line_end", got.line_end, want.line_end);
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == CH_EQ || b == CH_QUOTE || b == CH_BSL || b == CH_SPACE || b == CH_TAB);
        return b;
    endfunction

    function automatic logic [7:0] ws_byte();
        return $urandom_range(1) ? CH_SPACE : CH_TAB;
    endfunction

    function automatic logic [7:0] special_byte();
        case ($urandom_range(4))
            0: return CH_EQ;
            1: return CH_QUOTE;
            2: return CH_BSL;
            3: return CH_SPACE;
            default: return CH_TAB;
        endcase
    endfunction

    function automatic logic [7:0] nonws_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == CH_SPACE || b == CH_TAB);
        return b;
    endfunction

    function automatic logic [7:0] quoted_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == CH_QUOTE || b == CH_BSL);
        return b;
    endfunction

    // Appends one byte to the line under construction.
    task automatic put_byte(input logic [7:0] b);
        line_buf.insert(line_buf.size(), b);
    endtask

    task automatic put_str(input string s);
        foreach (s[i])
            put_byte(s[i]);
    endtask

    // Moves the line under construction into the feed, flagging its final byte.
    task automatic flush_line(input bit hold);
        feed_t f;
        if (line_buf.size() == 0)
            put_byte(CH_EQ);
        foreach (line_buf[i])
        begin
            f.data = line_buf[i];
            f.last = (i == line_buf.size() - 1);
            f.hold = hold && (i == 0);
            byte_feed.insert(byte_feed.size(), f);
        end
        line_buf.delete();
    endtask

    task automatic add_wellformed_line();
        int pairs;
        int kind;
        bit open_quote;
        pairs = $urandom_range(6, 1);
        for (int p = 0; p < pairs; p++)
        begin
            if ($urandom_range(3) == 0)
                put_byte(ws_byte());
            // Now and then a bare token that is dropped.
            if ($urandom_range(4) == 0)
            begin
                repeat ($urandom_range(3, 1))
                    put_byte(plain_byte());
                put_byte(ws_byte());
            end
            if ($urandom_range(9) != 0)
                repeat ($urandom_range(4, 1))
                    put_byte(plain_byte());
            put_byte(CH_EQ);
            kind = $urandom_range(2);
            if (kind == 1)
            begin
                put_byte(($urandom_range(3) == 0) ? CH_EQ : plain_byte());
                repeat ($urandom_range(4))
                    put_byte(nonws_byte());
            end
            else if (kind == 2)
            begin
                put_byte(CH_QUOTE);
                repeat ($urandom_range(5))
                begin
                    if ($urandom_range(3) == 0)
                    begin
                        put_byte(CH_BSL);
                        put_byte(8'($urandom_range(255)));
                    end
                    else
                        put_byte(quoted_byte());
                end
                open_quote = (p == pairs - 1) && ($urandom_range(4) == 0);
                if (!open_quote)
                    put_byte(CH_QUOTE);
                else if ($urandom_range(1))
                    put_byte(CH_BSL);
            end
            if (p != pairs - 1)
            begin
                // A closing quote may be followed directly by the next key.
                if (!(kind == 2 && $urandom_range(4) == 0))
                    repeat ($urandom_range(2, 1))
                        put_byte(ws_byte());
            end
            else if ($urandom_range(1) && !(kind == 2 && open_quote))
                put_byte(ws_byte());
        end
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(3, 1))
                put_byte(plain_byte());
    endtask

    task automatic add_noise_line();
        repeat ($urandom_range(12, 1))
            put_byte($urandom_range(1) ? special_byte() : 8'($urandom_range(255)));
    endtask

    task automatic build_stimulus();
        int start;
        // Key of byte 0x00, quoted value with an escaped quote, a dropped token,
        // an empty key with an empty value, and a key of 0xFF left open at the end.
        put_byte(8'h00);
        put_str("=\"a\\\"\"x = ");
        put_byte(8'hFF);
        flush_line(1'b0);
        // Equals inside a value, tab ending it, and an equals on the last byte.
        put_str("v==w\t=");
        flush_line(1'b0);
        // Unterminated quote with a backslash on the last byte.
        put_str("=\"\\");
        flush_line(1'b0);
        put_str("=q");
        flush_line(1'b0);
        put_str("z");
        flush_line(1'b0);

        // One line with enough pairs to saturate the count.
        for (int i = 0; i < 260; i++)
        begin
            case (i % 3)
                0: put_str("= ");
                1: put_str("=v ");
                default: put_str("=\"\"");
            endcase
        end
        flush_line(1'b1);

        start = byte_feed.size();
        while (byte_feed.size() - start < RANDOM_BYTES)
        begin
            if ($urandom_range(3) == 0)
                add_noise_line();
            else
                add_wellformed_line();
            flush_line($urandom_range(29) == 0);
        end
        total_bytes = byte_feed.size();
    endtask

    // Monitor, scoreboard and watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            quiet_cycles = quiet_cycles + 1;
            if (bytes_if.valid && bytes_if.ready)
            begin
                tag_expect.insert(tag_expect.size(),
                                  tag_byte(bytes_if.byte_in, bytes_if.last_in));
                in_fired = 1'b1;
                bytes_taken = bytes_taken + 1;
                quiet_cycles = 0;
            end
            if (tags_if.valid && tags_if.ready)
            begin
                seen_tag.byte_out = tags_if.byte_out;
                seen_tag.role = tags_if.role;
                seen_tag.key_commit = tags_if.key_commit;
                seen_tag.key_discard = tags_if.key_discard;
                seen_tag.pair_end = tags_if.pair_end;
                seen_tag.line_pairs = tags_if.line_pairs;
                seen_tag.line_end = tags_if.line_end;
                check_tag(seen_tag);
                tags_seen = tags_seen + 1;
                quiet_cycles = 0;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Byte driver.
    always @(negedge clk)
    begin
        if (!(bytes_if.valid && !in_fired))
        begin
            if (in_fired)
            begin
                byte_feed.delete(0);
                in_fired = 1'b0;
            end
            if (rst_n && byte_feed.size() != 0
                && !(byte_feed[0].hold && tag_expect.size() != 0)
                && $urandom_range(99) >= send_idle_pct())
            begin
                bytes_if.valid <= 1'b1;
                bytes_if.byte_in <= byte_feed[0].data;
                bytes_if.last_in <= byte_feed[0].last;
            end
            else
                bytes_if.valid <= 1'b0;
        end
    end

    // Result receiver.
    always @(negedge clk)
    begin
        tags_if.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct());
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        bytes_if.valid = 1'b0;
        bytes_if.byte_in = '0;
        bytes_if.last_in = 1'b0;
        tags_if.ready = 1'b0;
        scan_st = ST_SKIP;
        pair_cnt = '0;
        bytes_taken = 0;
        tags_seen = 0;
        error_count = 0;
        quiet_cycles = 0;
        in_fired = 1'b0;
        total_bytes = 0;
        build_stimulus();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        while (byte_feed.size() != 0 || tag_expect.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
